/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tis_pkg.sv */
package tis_pkg;

  // level accumulator holds base + step * index exactly for up to 256 levels
  localparam int T_W = 42;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 65;
  localparam int NUM_W = 66;
  localparam int MIN_LEVELS = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] pos_ax;
    logic signed [31:0] pos_ay;
    logic signed [31:0] pos_bx;
    logic signed [31:0] pos_by;
    logic signed [31:0] pos_cx;
    logic signed [31:0] pos_cy;
  } triangle_t;

  typedef struct packed {
    logic               seg_valid;
    logic [5:0]         level_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               last_seg;
  } segment_t;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_STEP  = 2'd1,
    REG_COUNT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] level_base;
    logic [30:0]        level_step;
    logic [6:0]         level_count;
  } cfg_t;

  // triangle edges in test order: (2,0), (0,1), (1,2)
  typedef enum logic [1:0] {
    EDGE_CA = 2'd0,
    EDGE_AB = 2'd1,
    EDGE_BC = 2'd2
  } edge_t;

  typedef struct packed {
    logic                  seg_valid;
    logic                  last_seg;
    logic [5:0]            level_index;
    logic signed [T_W-1:0] level;
    edge_t                 edge0;
    edge_t                 edge1;
    triangle_t             shape;
  } job_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_SCAN,
    FRONT_FLUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_DIFF,
    BACK_MUL,
    BACK_SUM,
    BACK_DIV,
    BACK_LOAD
  } back_state_t;

  // one end <= level and the other above it
  function automatic logic crossed(logic signed [31:0] va, logic signed [31:0] vb,
                                   logic signed [T_W-1:0] t);
    logic signed [T_W-1:0] wa;
    logic signed [T_W-1:0] wb;
    wa = T_W'(va);
    wb = T_W'(vb);
    return (wa <= t && wb > t) || (wb <= t && wa > t);
  endfunction

  function automatic logic [1:0] edge_from(edge_t e);
    unique case (e)
      EDGE_CA: return 2'd2;
      EDGE_AB: return 2'd0;
      EDGE_BC: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] edge_to(edge_t e);
    unique case (e)
      EDGE_CA: return 2'd0;
      EDGE_AB: return 2'd1;
      EDGE_BC: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] vertex_value(triangle_t shape, logic [1:0] idx);
    case (idx)
      2'd0:    return shape.value_a;
      2'd1:    return shape.value_b;
      default: return shape.value_c;
    endcase
  endfunction

  function automatic logic signed [31:0] vertex_x(triangle_t shape, logic [1:0] idx);
    case (idx)
      2'd0:    return shape.pos_ax;
      2'd1:    return shape.pos_bx;
      default: return shape.pos_cx;
    endcase
  endfunction

  function automatic logic signed [31:0] vertex_y(triangle_t shape, logic [1:0] idx);
    case (idx)
      2'd0:    return shape.pos_ay;
      2'd1:    return shape.pos_by;
      default: return shape.pos_cy;
    endcase
  endfunction

endpackage

/* rtl/tis_queue.sv */
module tis_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tis_pkg::job_t  push_data,
  output logic           full,
  input  logic           pop,
  output tis_pkg::job_t  pop_data,
  output logic           empty
);

  localparam int PTR_W = $clog2(tis_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tis_pkg::QUEUE_DEPTH + 1);

  tis_pkg::job_t    slots [tis_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(tis_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tis_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tis_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tis_div.sv */
module tis_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tis_pkg::NUM_W-1:0]    num,
  input  logic signed [tis_pkg::DIFF_W-1:0]   den,
  output logic                                done,
  output logic signed [31:0]                  quot
);

  logic                               busy;
  logic [4:0]                         cnt;
  logic [tis_pkg::DIFF_W-1:0]         rem;
  logic [tis_pkg::DIFF_W-1:0]         dmag;
  logic [31:0]                        shifter;
  logic [31:0]                        q;
  logic                               neg;
  logic [tis_pkg::NUM_W-1:0]          num_mag;
  logic [tis_pkg::DIFF_W:0]           rem_sh;
  logic                               ge;

  // magnitudes; quotient fits 32 bits so the top half starts below the divisor
  assign num_mag = num[tis_pkg::NUM_W-1] ? tis_pkg::NUM_W'(-num) : tis_pkg::NUM_W'(num);
  assign rem_sh  = {rem, shifter[31]};
  assign ge      = (rem_sh >= {1'b0, dmag});
  assign quot    = neg ? -$signed(q) : $signed(q);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num_mag[tis_pkg::NUM_W-2 -: tis_pkg::DIFF_W];
      shifter <= num_mag[31:0];
      dmag    <= den[tis_pkg::DIFF_W-1] ? tis_pkg::DIFF_W'(-den) : tis_pkg::DIFF_W'(den);
      neg     <= num[tis_pkg::NUM_W-1] ^ den[tis_pkg::DIFF_W-1];
      q       <= '0;
    end else if (busy) begin
      rem     <= ge ? tis_pkg::DIFF_W'(rem_sh - {1'b0, dmag})
                    : rem_sh[tis_pkg::DIFF_W-1:0];
      shifter <= {shifter[30:0], 1'b0};
      q       <= {q[30:0], ge};
    end
  end

endmodule

/* rtl/tis_front.sv */
module tis_front #(
  parameter int MAX_LEVELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  tis_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  tis_pkg::triangle_t  triangle,
  output logic                q_push,
  input  logic                q_full,
  output tis_pkg::job_t       q_data
);

  localparam int IDX_W = $clog2(MAX_LEVELS);

  tis_pkg::front_state_t         state;
  tis_pkg::front_state_t         state_next;
  tis_pkg::triangle_t            shape;
  logic signed [tis_pkg::T_W-1:0] level;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              last_idx;
  logic                          pend_valid;
  logic [5:0]                    pend_index;
  logic signed [tis_pkg::T_W-1:0] pend_level;
  tis_pkg::edge_t                pend_e0;
  tis_pkg::edge_t                pend_e1;
  logic                          c_ca;
  logic                          c_ab;
  logic                          c_bc;
  logic                          hit;
  logic                          need_push;
  logic                          advance;
  logic [8:0]                    lc9;
  logic [8:0]                    cnt9;

  // edge tests for the level under scan
  assign c_ca      = tis_pkg::crossed(shape.value_c, shape.value_a, level);
  assign c_ab      = tis_pkg::crossed(shape.value_a, shape.value_b, level);
  assign c_bc      = tis_pkg::crossed(shape.value_b, shape.value_c, level);
  assign hit       = (c_ca && c_ab) || (c_ca && c_bc) || (c_ab && c_bc);
  assign need_push = (state == tis_pkg::FRONT_SCAN) && hit && pend_valid;
  assign advance   = !need_push || !q_full;

  // level count clamp
  assign lc9  = 9'(cfg.level_count);
  assign cnt9 = (lc9 < 9'(tis_pkg::MIN_LEVELS)) ? 9'(tis_pkg::MIN_LEVELS) :
                (lc9 > 9'(MAX_LEVELS))          ? 9'(MAX_LEVELS) : lc9;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tis_pkg::FRONT_IDLE: begin
        if (push) state_next = tis_pkg::FRONT_SCAN;
      end
      tis_pkg::FRONT_SCAN: begin
        if (advance && idx == last_idx) state_next = tis_pkg::FRONT_FLUSH;
      end
      tis_pkg::FRONT_FLUSH: begin
        if (!q_full) state_next = tis_pkg::FRONT_IDLE;
      end
      default: state_next = tis_pkg::FRONT_IDLE;
    endcase
  end

  // outputs: a crossing is held back until the next one is found, so the last one can be marked
  always_comb begin
    full   = (state != tis_pkg::FRONT_IDLE);
    q_push = 1'b0;
    q_data = '0;
    q_data.shape       = shape;
    q_data.seg_valid   = pend_valid;
    q_data.level_index = pend_index;
    q_data.level       = pend_level;
    q_data.edge0       = pend_e0;
    q_data.edge1       = pend_e1;
    unique case (state)
      tis_pkg::FRONT_SCAN: begin
        q_push = need_push && !q_full;
      end
      tis_pkg::FRONT_FLUSH: begin
        q_push          = !q_full;
        q_data.last_seg = 1'b1;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tis_pkg::FRONT_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tis_pkg::FRONT_FLUSH && !q_full) begin
        pend_valid <= 1'b0;
      end else if (state == tis_pkg::FRONT_SCAN && advance && hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // triangle capture and level scan
  always_ff @(posedge clk) begin
    if (state == tis_pkg::FRONT_IDLE && push) begin
      shape    <= triangle;
      level    <= tis_pkg::T_W'(cfg.level_base);
      idx      <= '0;
      last_idx <= IDX_W'(cnt9 - 9'd1);
    end else if (state == tis_pkg::FRONT_SCAN && advance) begin
      level <= level + tis_pkg::T_W'(cfg.level_step);
      idx   <= idx + 1'b1;
      if (hit) begin
        pend_index <= 6'(idx);
        pend_level <= level;
        pend_e0    <= c_ca ? tis_pkg::EDGE_CA : tis_pkg::EDGE_AB;
        pend_e1    <= (c_ca && c_ab) ? tis_pkg::EDGE_AB : tis_pkg::EDGE_BC;
      end
    end
  end

endmodule

/* rtl/tis_back.sv */
module tis_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  tis_pkg::job_t      q_data,
  output logic               empty,
  input  logic               pop,
  output tis_pkg::segment_t  segment
);

  tis_pkg::back_state_t              state;
  tis_pkg::back_state_t              state_next;
  tis_pkg::job_t                     job;
  logic [1:0]                        k;
  logic signed [tis_pkg::DIFF_W-1:0] d_a;
  logic signed [tis_pkg::DIFF_W-1:0] d_b;
  logic signed [tis_pkg::DIFF_W-1:0] den;
  logic signed [31:0]                pa;
  logic signed [31:0]                pb;
  logic signed [tis_pkg::PROD_W-1:0] pr0;
  logic signed [tis_pkg::PROD_W-1:0] pr1;
  logic signed [31:0]                res [4];
  logic                              out_valid;
  tis_pkg::segment_t                 out_seg;
  tis_pkg::segment_t                 build;
  tis_pkg::edge_t                    sel_edge;
  logic [1:0]                        ia;
  logic [1:0]                        ib;
  logic signed [31:0]                va;
  logic signed [31:0]                vb;
  logic signed [tis_pkg::T_W:0]      wd_a;
  logic signed [tis_pkg::T_W:0]      wd_b;
  logic                              div_start;
  logic                              div_done;
  logic signed [31:0]                quot;
  logic signed [tis_pkg::NUM_W-1:0]  num;
  logic                              out_free;

  // endpoints of the edge for the coordinate in work (k: crossing, x or y)
  assign sel_edge = k[1] ? job.edge1 : job.edge0;
  assign ia       = tis_pkg::edge_from(sel_edge);
  assign ib       = tis_pkg::edge_to(sel_edge);
  assign va       = tis_pkg::vertex_value(job.shape, ia);
  assign vb       = tis_pkg::vertex_value(job.shape, ib);
  assign wd_b     = (tis_pkg::T_W + 1)'(vb) - (tis_pkg::T_W + 1)'(job.level);
  assign wd_a     = (tis_pkg::T_W + 1)'(job.level) - (tis_pkg::T_W + 1)'(va);
  assign num      = tis_pkg::NUM_W'(pr0) + tis_pkg::NUM_W'(pr1);
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign segment  = out_seg;

  tis_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // result assembly
  always_comb begin
    build = '0;
    build.last_seg = job.last_seg;
    if (job.seg_valid) begin
      build.seg_valid   = 1'b1;
      build.level_index = job.level_index;
      build.start_x     = res[0];
      build.start_y     = res[1];
      build.end_x       = res[2];
      build.end_y       = res[3];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tis_pkg::BACK_IDLE: begin
        if (!q_empty) begin
          state_next = q_data.seg_valid ? tis_pkg::BACK_DIFF : tis_pkg::BACK_LOAD;
        end
      end
      tis_pkg::BACK_DIFF: state_next = tis_pkg::BACK_MUL;
      tis_pkg::BACK_MUL:  state_next = tis_pkg::BACK_SUM;
      tis_pkg::BACK_SUM:  state_next = tis_pkg::BACK_DIV;
      tis_pkg::BACK_DIV: begin
        if (div_done) begin
          state_next = (k == 2'd3) ? tis_pkg::BACK_LOAD : tis_pkg::BACK_DIFF;
        end
      end
      tis_pkg::BACK_LOAD: begin
        if (out_free) state_next = tis_pkg::BACK_IDLE;
      end
      default: state_next = tis_pkg::BACK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (state)
      tis_pkg::BACK_IDLE: q_pop     = !q_empty;
      tis_pkg::BACK_SUM:  div_start = 1'b1;
      default: begin
        q_pop     = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tis_pkg::BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tis_pkg::BACK_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath: differences, products, quotient per coordinate
  always_ff @(posedge clk) begin
    if (state == tis_pkg::BACK_IDLE && !q_empty) begin
      job <= q_data;
      k   <= '0;
    end
    if (state == tis_pkg::BACK_DIFF) begin
      d_b <= tis_pkg::DIFF_W'(wd_b);
      d_a <= tis_pkg::DIFF_W'(wd_a);
      den <= tis_pkg::DIFF_W'(vb) - tis_pkg::DIFF_W'(va);
      pa  <= k[0] ? tis_pkg::vertex_y(job.shape, ia) : tis_pkg::vertex_x(job.shape, ia);
      pb  <= k[0] ? tis_pkg::vertex_y(job.shape, ib) : tis_pkg::vertex_x(job.shape, ib);
    end
    if (state == tis_pkg::BACK_MUL) begin
      pr0 <= tis_pkg::PROD_W'(pa) * tis_pkg::PROD_W'(d_b);
      pr1 <= tis_pkg::PROD_W'(pb) * tis_pkg::PROD_W'(d_a);
    end
    if (state == tis_pkg::BACK_DIV && div_done) begin
      res[k] <= quot;
      k      <= k + 1'b1;
    end
    if (state == tis_pkg::BACK_LOAD && out_free) begin
      out_seg <= build;
    end
  end

endmodule

/* rtl/triangle_isoline_segments_core.sv */
// channel  | handshake           | payload
// triangle | push / full         | triangle_t: vertex values and positions, Q16.16
// segment  | pop / empty         | segment_t: one isoline segment per crossed level, or one empty last result
// config   | cfg_we, cfg_index   | cfg_data: level_base, level_step, level_count
//
// The front scans one level a cycle while the job queue takes its crossings. It holds
// full from an accepted push until its last job is queued (level_count clamped to
// 10..MAX_LEVELS). In the back each segment is built from four coordinates, each a difference,
// a multiply, a sum and a bit-serial divide, after a step to take the job and before
// one to load the result; a triangle with no crossing goes straight to the load. Either
// side stalls on its own across a two-entry job queue. Reset (rst, synchronous) empties
// the job queue and output and restores the registers to base 0, step 1.0, ten levels.
`include "assert_macros.svh"

module triangle_isoline_segments_core #(
  parameter int MAX_LEVELS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tis_pkg::triangle_t triangle,
  output logic               empty,
  input  logic               pop,
  output tis_pkg::segment_t  segment,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  tis_pkg::cfg_t cfg;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  tis_pkg::job_t q_in;
  tis_pkg::job_t q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_base  <= '0;
      cfg.level_step  <= 31'd65536;
      cfg.level_count <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tis_pkg::REG_BASE:  cfg.level_base  <= $signed(cfg_data);
        tis_pkg::REG_STEP:  cfg.level_step  <= cfg_data[30:0];
        tis_pkg::REG_COUNT: cfg.level_count <= cfg_data[6:0];
        default:            cfg.level_count <= cfg.level_count;
      endcase
    end
  end

  tis_front #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .triangle (triangle),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_in)
  );

  tis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .empty   (empty),
    .pop     (pop),
    .segment (segment)
  );

  // checks
  `ASSERT_NEXT(a_accept_blocks, clk, rst, push && !full, full, "front took a second item")
  `ASSERT_IMPLIES(a_empty_is_last, clk, rst, !empty && !segment.seg_valid, segment.last_seg, "no-crossing result not last")
  `ASSERT_IMPLIES(a_empty_zero, clk, rst, !empty && !segment.seg_valid, segment.level_index == 6'd0 && segment.start_x == 32'sd0 && segment.end_y == 32'sd0, "no-crossing result not cleared")
  `ASSERT_IMPLIES(a_job_last, clk, rst, q_push && !q_in.seg_valid, q_in.last_seg, "empty job without last mark")

endmodule
